/* rtl/acm_pkg.sv */
// Package for the zero-key AES-128 CBC-MAC core: payload types, round keys and S-box.
// Used by every module in rtl/.
package acm_pkg;

    typedef struct packed {
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic [4:0]  byte_count;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] tag_hi;
        logic [63:0] tag_lo;
    } t_out_item;

    // Classified request handed from the front end to the AES engine.
    typedef struct packed {
        logic [127:0] block;
        logic         encrypt;
        logic         last;
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_eng_state;

    localparam int unsigned BlockBytes = 16;
    localparam int unsigned NumRounds  = 10;
    localparam int unsigned QueueDepth = 2;

    localparam logic [4:0] TagReset = 5'd16;

    // Round keys 1..10 of the all-zero key; round key 0 is zero.
    function automatic logic [127:0] round_key(input logic [3:0] rnd);
        logic [127:0] k;
        begin
            unique case (rnd)
                4'd1:    k = 128'h62636363626363636263636362636363;
                4'd2:    k = 128'h9b9898c9f9fbfbaa9b9898c9f9fbfbaa;
                4'd3:    k = 128'h90973450696ccffaf2f457330b0fac99;
                4'd4:    k = 128'hee06da7b876a1581759e42b27e91ee2b;
                4'd5:    k = 128'h7f2e2b88f8443e098dda7cbbf34b9290;
                4'd6:    k = 128'hec614b851425758c99ff09376ab49ba7;
                4'd7:    k = 128'h217517873550620bacaf6b3cc61bf09b;
                4'd8:    k = 128'h0ef903333ba9613897060a04511dfa9f;
                4'd9:    k = 128'hb1d4d8e28a7db9da1d7bb3de4c664941;
                4'd10:   k = 128'hb4ef5bcb3e92e21123e951cf6f8f188e;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] s [256];
        begin
            s = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
            return s[a];
        end
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round without the key add; byte 0 sits in bits 127:120.
    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic final_rnd);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] res;
        begin
            for (int k = 0; k < 16; k++) s[k] = st[127-8*k -: 8];
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[r+4*c] = sbox(s[r+4*((c+r)%4)]);
            if (!final_rnd) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
                end
            end
            for (int k = 0; k < 16; k++) res[127-8*k -: 8] = t[k];
            return res;
        end
    endfunction

endpackage

/* rtl/acm_front.sv */
// Front end of the CBC-MAC core: masks the block, drops empty non-last items and
// queues requests for the engine. Depends on acm_pkg.
module acm_front import acm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_req_valid,
    input  logic     i_req_take,
    output t_req     o_req
);

    t_req       r_q [QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [127:0] mask;
    logic [4:0]   cnt_sat;
    t_req         req_in;
    logic         push, pop, acc;

    assign cnt_sat = (i_item.byte_count > 5'd16) ? 5'd16 : i_item.byte_count;

    always_comb begin
        for (int k = 0; k < BlockBytes; k++)
            mask[127-8*k -: 8] = (5'(k) < cnt_sat) ? 8'hff : 8'h00;
    end

    assign req_in.block   = {i_item.block_hi, i_item.block_lo} & mask;
    assign req_in.encrypt = (cnt_sat != 5'd0);
    assign req_in.last    = i_item.last;

    assign o_stall     = (r_cnt == 2'(QueueDepth));
    assign acc         = i_valid && !o_stall;
    // Items with no bytes and no last flag have no effect at all.
    assign push        = acc && (req_in.encrypt || req_in.last);
    assign o_req_valid = (r_cnt != 2'd0);
    assign pop         = o_req_valid && i_req_take;
    assign o_req       = r_q[r_rp];
    assign n_cnt       = r_cnt + 2'(push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= req_in;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QueueDepth)) else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QueueDepth)) |-> !push) else $error("push into full queue");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp)) else $error("pointer mismatch");

endmodule

/* rtl/acm_engine.sv */
// AES-128 engine of the CBC-MAC core: one round per cycle on the chain value,
// tag truncation and an output register. Depends on acm_pkg.
module acm_engine import acm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_take,
    input  t_req      i_req,
    input  logic [4:0] i_tag_bytes,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_eng_state r_state, n_state;
    logic [127:0] r_chain, n_chain;
    logic [3:0]   r_rnd, n_rnd;
    logic         r_last, n_last;
    logic         r_ovalid, n_ovalid;
    t_out_item    r_out, n_out;
    logic [127:0] tmask;
    logic [4:0]   keep;
    logic         out_free;

    assign keep     = (i_tag_bytes > 5'd16) ? 5'd16 : i_tag_bytes;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        for (int k = 0; k < BlockBytes; k++)
            tmask[127-8*k -: 8] = (5'(k) < keep) ? 8'hff : 8'h00;
    end

    always_comb begin
        n_state    = r_state;
        n_chain    = r_chain;
        n_rnd      = r_rnd;
        n_last     = r_last;
        n_out      = r_out;
        n_ovalid   = r_ovalid && i_stall;
        o_req_take = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_req_take = 1'b1;
                    n_last     = i_req.last;
                    if (i_req.encrypt) begin
                        n_chain = r_chain ^ i_req.block;
                        n_rnd   = 4'd1;
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_RUN: begin
                n_chain = aes_round(r_chain, r_rnd == 4'(NumRounds)) ^ round_key(r_rnd);
                n_rnd   = r_rnd + 4'd1;
                if (r_rnd == 4'(NumRounds))
                    n_state = r_last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out    = {r_chain & tmask};
                    n_ovalid = 1'b1;
                    n_chain  = '0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= '0;
            r_ovalid <= 1'b0;
            r_rnd    <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_ovalid <= n_ovalid;
            r_rnd    <= n_rnd;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_take |-> (r_state == ST_IDLE)) else $error("request taken while busy");
    a_chain_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (r_chain == '0 && r_ovalid))
        else $error("chain not cleared after tag");
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rnd >= 4'd1 && r_rnd <= 4'(NumRounds)))
        else $error("round counter out of range");

endmodule

/* rtl/aes_cbc_mac_zero_key_core.sv */
// A block accepted into the queue is taken by the engine when it is idle and runs through
// the AES rounds in ST_RUN; a last item then passes through ST_OUT to the tag register, and a
// count-zero last item goes from ST_IDLE straight to ST_OUT. The engine finishes a block
// before it takes another one, and ST_OUT waits while the tag register is stalled.
// A two-entry queue lets input be accepted while the engine works.
// Synchronous active-low reset clears the chain value, queue and tag length (16).
module aes_cbc_mac_zero_key_core import acm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_item,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    logic [4:0] r_tag_bytes;
    logic       req_valid, req_take;
    t_req       req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tag_bytes <= TagReset;
        else if (i_cfg_we) r_tag_bytes <= i_cfg_data;
    end

    acm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_req_valid(req_valid), .i_req_take(req_take), .o_req(req)
    );

    acm_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(req_valid), .o_req_take(req_take),
        .i_req(req), .i_tag_bytes(r_tag_bytes), .o_valid(o_valid), .i_stall(i_stall),
        .o_item(o_item)
    );

endmodule

/* dv/tb_aes_cbc_mac_zero_key_core.sv */
// Testbench for the zero-key AES-128 CBC-MAC core: random and directed requests,
// with an in-bench AES predictor checking every emitted tag.
// Depends on acm_pkg and aes_cbc_mac_zero_key_core from rtl/.
module tb_aes_cbc_mac_zero_key_core;
    import acm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_stall;
    t_out_item  o_item;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;

    aes_cbc_mac_zero_key_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    t_in_item   pending_reqs[$];
    t_out_item  expected_tags[$];
    logic [127:0] mac_chain;
    logic [4:0]   tag_len;
    int errors;
    int drv_gap;
    int mon_gap;
    int hold_cycles;

    // S-box and key schedule for the zero key, computed independently of the package constants.
    logic [7:0] sb [256];
    logic [7:0] rkeys [176];

    function automatic logic [7:0] gmul2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic build_tables();
        logic [7:0] p, q, x, rc, f;
        logic [7:0] t[4];
        p = 8'h01;
        q = 8'h01;
        sb[0] = 8'h63;
        // Walk the multiplicative group with generator 3 to derive the S-box.
        do begin
            p = p ^ gmul2(p);
            q = q ^ (q << 1);
            q = q ^ (q << 2);
            q = q ^ (q << 4);
            if (q[7]) q = q ^ 8'h09;
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                ^ {q[3:0], q[7:4]} ^ 8'h63;
            sb[p] = x;
        end while (p != 8'h01);
        for (int i = 0; i < 16; i++) rkeys[i] = 8'h00;
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = rkeys[i-4+j];
            if (i % 16 == 0) begin
                f = t[0];
                t[0] = sb[t[1]] ^ rc;
                t[1] = sb[t[2]];
                t[2] = sb[t[3]];
                t[3] = sb[f];
                rc = gmul2(rc);
            end
            for (int j = 0; j < 4; j++) rkeys[i+j] = rkeys[i-16+j] ^ t[j];
        end
    endtask

    function automatic logic [127:0] encrypt_zero_key(input logic [127:0] blk);
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] a0, a1, a2, a3, mix;
        logic [127:0] res;
        for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[r+4*c] = sb[s[r+4*((c+r)%4)]];
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    mix = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ mix ^ gmul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ mix ^ gmul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ mix ^ gmul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ mix ^ gmul2(a3 ^ a0);
                end
            end
            for (int k = 0; k < 16; k++) s[k] = t[k] ^ rkeys[16*rnd+k];
        end
        for (int k = 0; k < 16; k++) res[127-8*k -: 8] = s[k];
        return res;
    endfunction

    task automatic predict_tag(input t_in_item req);
        int cnt;
        int keep;
        logic [127:0] msg;
        logic [127:0] tag;
        t_out_item exp_tag;
        cnt = (req.byte_count > 16) ? 16 : req.byte_count;
        keep = (tag_len > 16) ? 16 : tag_len;
        if (cnt > 0) begin
            msg = {req.block_hi, req.block_lo};
            for (int k = cnt; k < 16; k++) msg[127-8*k -: 8] = 8'h00;
            mac_chain = encrypt_zero_key(mac_chain ^ msg);
        end
        if (req.last) begin
            tag = mac_chain;
            for (int k = keep; k < 16; k++) tag[127-8*k -: 8] = 8'h00;
            exp_tag.tag_hi = tag[127:64];
            exp_tag.tag_lo = tag[63:0];
            expected_tags.push_back(exp_tag);
            mac_chain = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tag %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    function automatic t_in_item make_req(input logic [4:0] cnt, input logic lst);
        t_in_item r;
        r.block_hi = {$urandom, $urandom};
        r.block_lo = {$urandom, $urandom};
        r.byte_count = cnt;
        r.last = lst;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Driver: a request stays on the bus until accepted; a random gap may follow.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap <= 0;
        end else if (i_valid && !o_stall) begin
            predict_tag(i_item);
            void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && drv_gap == 0 && $urandom_range(0, 3) == 0) begin
                i_item <= pending_reqs[0];
            end else begin
                i_valid <= 1'b0;
                drv_gap <= $urandom_range(0, 11);
            end
        end else if (!i_valid) begin
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                i_valid <= 1'b1;
                i_item <= pending_reqs[0];
            end
        end
    end

    // Monitor: compares each accepted tag, then may stall the core at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            mon_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_tags.size() == 0) begin
                    report_mismatch("with no request pending", o_item.tag_hi, '0);
                end else begin
                    if (o_item.tag_hi !== expected_tags[0].tag_hi)
                        report_mismatch("hi", o_item.tag_hi, expected_tags[0].tag_hi);
                    if (o_item.tag_lo !== expected_tags[0].tag_lo)
                        report_mismatch("lo", o_item.tag_lo, expected_tags[0].tag_lo);
                    void'(expected_tags.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end else if (mon_gap > 0) begin
                i_stall <= 1'b1;
                mon_gap <= mon_gap - 1;
            end else if (o_valid && !i_stall && $urandom_range(0, 2) != 0) begin
                i_stall <= 1'b1;
                mon_gap <= $urandom_range(0, 11);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_tag_len(input logic [4:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tag_len = v;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid || expected_tags.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic random_message(input int nblocks);
        for (int b = 0; b < nblocks; b++) begin
            pending_reqs.push_back(make_req($urandom_range(0, 4) == 0
                ? 5'($urandom_range(0, 31)) : 5'd16, b == nblocks - 1));
        end
    endtask

    initial begin
        logic [4:0] settings[6];
        t_in_item r;
        int burst;
        errors = 0;
        hold_cycles = 0;
        mac_chain = '0;
        tag_len = TagReset;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        build_tables();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: empty message, field extremes, counts past sixteen,
        // ignored bytes past the count, and zero-count items mid message.
        r = '0; r.last = 1'b1; pending_reqs.push_back(r);
        r = '0; r.byte_count = 5'd16; r.last = 1'b1; pending_reqs.push_back(r);
        r = '1; pending_reqs.push_back(r);
        r = '1; r.byte_count = 5'd16; r.last = 1'b1; pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(5'd1, 1'b1));
        pending_reqs.push_back(make_req(5'd15, 1'b0));
        pending_reqs.push_back(make_req(5'd0, 1'b0));
        pending_reqs.push_back(make_req(5'd8, 1'b1));
        pending_reqs.push_back(make_req(5'd17, 1'b0));
        pending_reqs.push_back(make_req(5'd0, 1'b1));
        for (int c = 0; c <= 16; c += 4) pending_reqs.push_back(make_req(5'(c), c == 16));
        drain();

        settings = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd16};
        foreach (settings[s]) begin
            write_tag_len(settings[s]);
            if (s == 2) begin
                // Hold the receiver off while whole messages queue up behind it.
                hold_cycles = 300;
            end
            burst = 0;
            while (burst < 165) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_reqs.push_back(make_req(5'($urandom_range(0, 31)),
                                                    1'($urandom_range(0, 1))));
                    burst++;
                end else begin
                    r.byte_count = 5'($urandom_range(1, 6));
                    random_message(r.byte_count);
                    burst += r.byte_count;
                end
            end
            drain();
        end
        if (errors == 0)
            $display("aes_cbc_mac_zero_key_core: match");
        else
            $display("aes_cbc_mac_zero_key_core: mismatch");
        $finish;
    end

    initial begin
        #5ms;
        $display("aes_cbc_mac_zero_key_core: mismatch");
        $finish;
    end
endmodule
